[rtl/multichannel_moving_average_macros.svh]
// Assertion macros for the multichannel moving average RTL.
// Included by the top level; expects clk and arst_n in the including module.
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication on clk, disabled while arst_n is low.
`define MMAVG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, disabled while arst_n is low.
`define MMAVG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mmavg_pkg.sv]
// Shared types and constants for the multichannel moving average.
// No dependencies; imported by the top level.
package mmavg_pkg;

	localparam int CH_FIELD_W   = 3;
	localparam int SAMPLE_W     = 32;
	localparam int WIN_FIELD_W  = 7;
	localparam logic [WIN_FIELD_W-1:0] WINDOW_LEN_RESET = 7'd10;

	typedef struct packed {
		logic [CH_FIELD_W-1:0]      channel;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [CH_FIELD_W-1:0]      out_channel;
		logic signed [SAMPLE_W-1:0] average;
		logic [WIN_FIELD_W-1:0]     fill_count;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_FETCH,
		S_DROP,
		S_ADD,
		S_DIVGO,
		S_DIV
	} seq_state_t;

endpackage

[rtl/mmavg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mmavg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/mmavg_div.sv]
// Serial restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero, one quotient bit per cycle. No dependencies.
module mmavg_div #(
	parameter int N_W = 38,
	parameter int D_W = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [N_W-1:0] dividend,
	input  logic [D_W-1:0]        divisor,
	output logic                  done,
	output logic signed [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [N_W-1:0]   mag_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   div_q;

	logic [D_W:0]     shifted;
	logic             ge;
	logic [D_W:0]     rem_nx;

	always_comb begin
		shifted = {rem_q, mag_q[N_W-1]};
		ge      = shifted >= {1'b0, div_q};
		rem_nx  = ge ? shifted - {1'b0, div_q} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[N_W-1];
			mag_q <= dividend[N_W-1] ? N_W'(-dividend) : N_W'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[N_W-2:0], ge};
			rem_q <= D_W'(rem_nx);
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

[rtl/multichannel_moving_average.sv]
// Channel   | Handshake                 | Payload
// item      | item_valid / item_ready   | mmavg_pkg::in_item_t (channel, sample)
// result    | result_valid / result_ready | mmavg_pkg::out_item_t
// cfg       | cfg_valid / cfg_ready     | cfg_window_len (7 bits)
//
// After an item transfer the sequencer steps through S_LOAD, S_FETCH, S_DROP, S_ADD, S_DIVGO
// and S_DIV, loads the output register as it leaves S_DIV, and takes no new item until S_IDLE.
// The serial divider, which produces one quotient bit per cycle, takes most of each item's time.
// Items for channels at or above CHANNELS are accepted and dropped in S_IDLE with no result.
// Reset and any window_len write clear every channel at once through valid bits.
// A result waiting in the output register does not block the next transfer, but the next
// quotient holds in the divider until that result leaves.
// Top level: sequencer, per-channel state RAM, sample RAM, divider.
// Depends on mmavg_pkg, mmavg_ram, mmavg_div and the assertion macro header.
`include "multichannel_moving_average_macros.svh"

module multichannel_moving_average #(
	parameter int CHANNELS   = 8,
	parameter int WINDOW_MAX = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  mmavg_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output mmavg_pkg::out_item_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [6:0]           cfg_window_len
);

	import mmavg_pkg::*;

	localparam int CH_W   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
	localparam int FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_W + SLOT_W;
	localparam int ST_W   = SUM_W + FILL_W + SLOT_W;
	localparam int SDEPTH = CHANNELS * WINDOW_MAX;
	localparam int SA_W   = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
	localparam int CMP_W  = FILL_W > WIN_FIELD_W ? FILL_W : WIN_FIELD_W;

	seq_state_t state_q, state_nx;

	logic [WIN_FIELD_W-1:0] window_len_q;
	logic [CHANNELS-1:0]    vld_q;
	logic [FILL_W-1:0]      eff_w;
	logic [CMP_W-1:0]       wl_ext;

	logic                   item_xfer, cfg_xfer, ch_ok;
	logic [CH_W-1:0]        ch_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [FILL_W-1:0]      fill_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   full_q;
	logic [SA_W-1:0]        smp_addr_q;

	logic [ST_W-1:0]        st_rdata, st_wdata;
	logic                   st_we;
	logic signed [SUM_W-1:0] rd_sum;
	logic [FILL_W-1:0]      rd_fill;
	logic [SLOT_W-1:0]      rd_slot;
	logic [SA_W-1:0]        smp_addr_c;
	logic [SAMPLE_W-1:0]    smp_rdata;
	logic                   smp_we;

	logic signed [SUM_W-1:0] sum_add;
	logic [FILL_W-1:0]      fill_new;
	logic [FILL_W:0]        slot_inc;
	logic [SLOT_W-1:0]      slot_new;

	logic                   div_start, div_done;
	logic signed [SUM_W-1:0] div_quot;
	logic                   out_free, out_load;
	logic                   result_valid_q;
	out_item_t              result_q;

	assign item_xfer = item_valid && item_ready;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign ch_ok     = 32'(item.channel) < 32'(CHANNELS);
	assign out_free  = !result_valid_q || result_ready;

	// Clamp window length into 1..WINDOW_MAX.
	always_comb begin
		wl_ext = CMP_W'(window_len_q);
		if (wl_ext == '0) begin
			eff_w = FILL_W'(1);
		end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
			eff_w = FILL_W'(WINDOW_MAX);
		end else begin
			eff_w = FILL_W'(wl_ext);
		end
	end

	// Unwritten channels read as zero state.
	always_comb begin
		if (vld_q[ch_q]) begin
			{rd_sum, rd_fill, rd_slot} = st_rdata;
		end else begin
			rd_sum  = '0;
			rd_fill = '0;
			rd_slot = '0;
		end
		smp_addr_c = SA_W'(SA_W'(ch_q) * SA_W'(WINDOW_MAX) + SA_W'(rd_slot));
	end

	always_comb begin
		sum_add  = sum_q + SUM_W'(sample_q);
		fill_new = full_q ? eff_w : fill_q + 1'b1;
		slot_inc = (FILL_W+1)'(slot_q) + 1'b1;
		slot_new = (slot_inc >= (FILL_W+1)'(eff_w)) ? '0 : SLOT_W'(slot_inc);
		st_wdata = {sum_add, fill_new, slot_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx   = state_q;
		item_ready = 1'b0;
		cfg_ready  = 1'b0;
		st_we      = 1'b0;
		smp_we     = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				cfg_ready  = 1'b1;
				if (item_xfer && ch_ok) begin
					state_nx = S_LOAD;
				end
			end
			S_LOAD:  state_nx = S_FETCH;
			S_FETCH: state_nx = S_DROP;
			S_DROP:  state_nx = S_ADD;
			S_ADD: begin
				st_we    = 1'b1;
				smp_we   = 1'b1;
				state_nx = S_DIVGO;
			end
			S_DIVGO: begin
				div_start = 1'b1;
				state_nx  = S_DIV;
			end
			S_DIV: begin
				// Hold the quotient until the output register frees up.
				if (div_done && out_free) begin
					out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RESET;
			vld_q        <= '0;
		end else if (cfg_xfer) begin
			window_len_q <= cfg_window_len;
			vld_q        <= '0;
		end else if (st_we) begin
			vld_q[ch_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_xfer) begin
					ch_q     <= CH_W'(item.channel);
					sample_q <= item.sample;
				end
			end
			S_FETCH: begin
				sum_q      <= rd_sum;
				fill_q     <= rd_fill;
				slot_q     <= rd_slot;
				full_q     <= rd_fill >= eff_w;
				smp_addr_q <= smp_addr_c;
			end
			S_DROP: begin
				// Drop the oldest sample once the window is full.
				if (full_q) begin
					sum_q <= sum_q - SUM_W'($signed(smp_rdata));
				end
			end
			S_ADD: begin
				sum_q  <= sum_add;
				fill_q <= fill_new;
			end
			default: ;
		endcase
	end

	mmavg_ram #(
		.WIDTH (ST_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (ch_q),
		.wdata (st_wdata),
		.raddr (ch_q),
		.rdata (st_rdata)
	);

	mmavg_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (SDEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (smp_addr_q),
		.wdata (sample_q),
		.raddr (smp_addr_c),
		.rdata (smp_rdata)
	);

	mmavg_div #(
		.N_W (SUM_W),
		.D_W (FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.out_channel <= CH_FIELD_W'(ch_q);
			result_q.average     <= div_quot[SAMPLE_W-1:0];
			result_q.fill_count  <= WIN_FIELD_W'(fill_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`MMAVG_ASSERT_NEXT(a_bad_ch, item_xfer && !ch_ok, state_q == S_IDLE, "bad channel started")
	`MMAVG_ASSERT_NOW(a_fill_rng, state_q == S_ADD, |fill_new && fill_new <= eff_w, "bad fill")
	`MMAVG_ASSERT_NEXT(a_load, out_load, result_valid && state_q == S_IDLE, "no result")

endmodule

[test/multichannel_moving_average_tb.sv]
// Self-checking testbench for multichannel_moving_average: per-channel boxcar averages.
// Predicts each result in place and checks it field by field.
// Depends on mmavg_pkg and the multichannel_moving_average RTL.
`timescale 1ns / 1ps

module multichannel_moving_average_tb;
	import mmavg_pkg::*;

	localparam int NUM_CH       = 8;
	localparam int WIN_MAX      = 64;
	localparam int RANDOM_ITEMS = 1100;
	localparam int IDLE_PCT     = 21;
	localparam int MAX_REPORTS  = 10;

	// sample flavors for the random phases
	typedef enum int {
		SMP_FULL,
		SMP_EXTREME,
		SMP_SMALL,
		SMP_ALL_MAX,
		SMP_ALL_MIN
	} sample_mode_t;

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        item_valid     = 1'b0;
	logic        item_ready;
	in_item_t    item           = '0;
	logic        result_valid;
	logic        result_ready   = 1'b0;
	out_item_t   result;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_window_len = 7'd0;

	// predictor state
	logic signed [31:0] ring_samples [NUM_CH][WIN_MAX];
	longint             window_sum   [NUM_CH];
	int                 window_fill  [NUM_CH];
	int                 next_slot    [NUM_CH];
	logic [6:0]         window_reg;

	out_item_t pending_averages[$];
	out_item_t expected_avg;
	int        mismatch_count = 0;
	bit        calm = 1'b0;

	multichannel_moving_average #(
		.CHANNELS(NUM_CH),
		.WINDOW_MAX(WIN_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_window_len(cfg_window_len)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int window_eff(logic [6:0] wl);
		if (wl == 7'd0)
			return 1;
		if (wl > WIN_MAX)
			return WIN_MAX;
		return int'(wl);
	endfunction

	function automatic void clear_windows();
		for (int c = 0; c < NUM_CH; c++) begin
			window_sum[c]  = 0;
			window_fill[c] = 0;
			next_slot[c]   = 0;
		end
	endfunction

	function automatic out_item_t predict_average(logic [2:0] ch, logic signed [31:0] val);
		out_item_t res;
		int        w;
		int        s;
		longint    q;
		w = window_eff(window_reg);
		s = next_slot[ch];
		if (s >= WIN_MAX)
			s = 0;
		if (window_fill[ch] >= w) begin
			// oldest sample sits in the slot about to be overwritten
			window_sum[ch] -= ring_samples[ch][s];
			window_fill[ch] = w;
		end else begin
			window_fill[ch]++;
		end
		ring_samples[ch][s] = val;
		window_sum[ch] += val;
		s++;
		if (s >= w)
			s = 0;
		next_slot[ch] = s;
		q = window_sum[ch] / window_fill[ch];
		res.out_channel = ch;
		res.average     = q[31:0];
		res.fill_count  = window_fill[ch][6:0];
		return res;
	endfunction

	function automatic logic signed [31:0] pick_sample(sample_mode_t mode);
		case (mode)
			SMP_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			SMP_SMALL:   return $signed($urandom_range(0, 2000)) - 32'sd1000;
			SMP_ALL_MAX: return 32'sh7FFF_FFFF;
			SMP_ALL_MIN: return 32'sh8000_0000;
			default:     return $urandom;
		endcase
	endfunction

	// receiver side: stall at random unless in a calm stretch
	always @(posedge clk)
		result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_averages.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result ch=%0d avg=%0d fill=%0d", $realtime,
						result.out_channel, result.average, result.fill_count);
			end else begin
				expected_avg = pending_averages.pop_front();
				if (result.out_channel !== expected_avg.out_channel ||
					result.average !== expected_avg.average ||
					result.fill_count !== expected_avg.fill_count) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"%0t: mismatch expected ch=%0d avg=%0d fill=%0d",
							" got ch=%0d avg=%0d fill=%0d"}, $realtime,
							expected_avg.out_channel, expected_avg.average,
							expected_avg.fill_count, result.out_channel,
							result.average, result.fill_count);
				end
			end
		end
	end

	task automatic send_sample(logic [2:0] ch, logic signed [31:0] val);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		item.channel <= ch;
		item.sample  <= val;
		do @(posedge clk); while (!item_ready);
		pending_averages.push_back(predict_average(ch, val));
	endtask

	// hold the sender until every expected average has come back
	task automatic wait_results();
		item_valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(logic [6:0] wl);
		wait_results();
		cfg_valid      <= 1'b1;
		cfg_window_len <= wl;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		window_reg = wl;
		clear_windows();
	endtask

	// reset window of 10: every channel, sample extremes, truncation toward zero
	task automatic test_default_window();
		send_sample(3'd0, 32'sh7FFF_FFFF);
		send_sample(3'd1, 32'sh8000_0000);
		send_sample(3'd2, -32'sd1);
		send_sample(3'd3, 32'sd1);
		send_sample(3'd4, 32'sd0);
		send_sample(3'd5, 32'sh0001_0000);
		send_sample(3'd6, 32'shFFFF_0000);
		send_sample(3'd7, 32'sh5555_5555);
		send_sample(3'd2, 32'sd0);
		send_sample(3'd3, 32'sd0);
		send_sample(3'd1, -32'sd3);
	endtask

	// window zero acts as one, window above the maximum acts as the maximum
	task automatic test_window_limits();
		write_window(7'd0);
		send_sample(3'd4, 32'sh8000_0000);
		send_sample(3'd4, 32'sh7FFF_FFFF);
		send_sample(3'd4, -32'sd7);
		write_window(7'd127);
		send_sample(3'd7, 32'sh7FFF_FFFF);
		send_sample(3'd7, 32'sh7FFF_FFFF);
		send_sample(3'd7, 32'sh8000_0000);
	endtask

	// pause the sender mid-stream until the block has drained
	task automatic test_drain_pause();
		write_window(7'd4);
		repeat (10)
			send_sample(3'($urandom_range(0, 1)), pick_sample(SMP_FULL));
		wait_results();
		repeat (20)
			send_sample(3'($urandom_range(0, 1)), pick_sample(SMP_SMALL));
	endtask

	function automatic logic [6:0] plan_window(int phase);
		case (phase % 12)
			0: return 7'd64;
			1: return 7'd127;
			2: return 7'd1;
			3: return 7'd0;
			4: return 7'd2;
			5: return 7'd65;
			6: return 7'd10;
			7: return 7'd63;
			8: return 7'd3;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic test_random_windows();
		int           phase;
		int           sent;
		int           n_items;
		int           n_chan;
		int           base_ch;
		int           w;
		sample_mode_t mode;
		phase = 0;
		sent  = 0;
		while (sent < RANDOM_ITEMS) begin
			write_window(plan_window(phase));
			w    = window_eff(window_reg);
			calm = (phase == 2 || phase == 3);
			// wide windows go to one channel so the ring wraps more than once
			if (w > 16) begin
				n_chan  = 1;
				n_items = 2 * w + $urandom_range(0, 20);
			end else begin
				n_chan  = $urandom_range(1, NUM_CH);
				n_items = $urandom_range(40, 120);
			end
			if (phase == 0)
				mode = SMP_ALL_MAX;
			else if (phase == 1)
				mode = SMP_ALL_MIN;
			else
				mode = sample_mode_t'($urandom_range(0, 4));
			base_ch = $urandom_range(0, NUM_CH - 1);
			repeat (n_items)
				send_sample(3'((base_ch + $urandom_range(0, n_chan - 1)) % NUM_CH),
					pick_sample(mode));
			sent += n_items;
			phase++;
		end
		calm = 1'b0;
	endtask

	initial begin
		window_reg = WINDOW_LEN_RESET;
		clear_windows();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_window_limits();
		test_drain_pause();
		test_random_windows();

		wait_results();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && pending_averages.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[multichannel_moving_average.f]
+incdir+rtl
rtl/mmavg_pkg.sv
rtl/mmavg_ram.sv
rtl/mmavg_div.sv
rtl/multichannel_moving_average.sv
test/multichannel_moving_average_tb.sv
